/* sv/lowest_common_ancestor_lifting_assert.svh */
// Assertion macros for the lowest common ancestor lifting block.
// Included by the top level; no other dependencies.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_ASSERT_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lcal_pkg.sv */
// Shared types and constants for the lowest common ancestor lifting block.
// No dependencies.
`default_nettype none

package lcal_pkg;

    localparam int NODE_W   = 10;  // node index field width
    localparam int DEPTH_W  = 10;  // depth field width
    localparam int CNT_W    = 11;  // node_count register width
    localparam int ENTRY_W  = NODE_W + 1;  // jump entry: valid + node
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    // Register index as decoded from paddr[2].
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] ancestor;
    } t_result;

endpackage

`default_nettype wire

/* sv/lcal_ram.sv */
// Simple dual-read, single-write synchronous RAM with registered read data.
// Used for the jump table and the depth store; no dependencies.
`default_nettype none

module lcal_ram #(
    parameter int W     = 11,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr0,
    input  wire logic [AW-1:0] i_raddr1,
    output      logic [W-1:0]  o_rdata0,
    output      logic [W-1:0]  o_rdata1
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd0;
    logic [W-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd0 <= r_mem[i_raddr0];
        r_rd1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

`default_nettype wire

/* sv/lcal_ctrl.sv */
// Sequencer for load, table build and query; owns the jump-table and depth RAMs.
// Depends on lcal_pkg and lcal_ram.
`default_nettype none

module lcal_ctrl import lcal_pkg::*; #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire t_op                i_op,
    input  wire logic [NODE_W-1:0]  i_node_a,
    input  wire logic [NODE_W-1:0]  i_node_b,
    input  wire logic               i_is_root,
    input  wire logic [DEPTH_W-1:0] i_node_depth,
    input  wire logic [CNT_W-1:0]   i_node_count,
    input  wire logic               i_res_ready,
    output      logic               o_res_valid,
    output      t_result            o_res
);

    localparam int NW  = $clog2(NODES);
    localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int JAW = NW + LW;
    localparam int CW  = (NW + 1 > CNT_W) ? NW + 1 : CNT_W;
    localparam logic [LW-1:0] TOP_LV = LW'(LEVELS - 1);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_BLD_A   = 13'b0000000000010,
        S_BLD_B   = 13'b0000000000100,
        S_BLD_C   = 13'b0000000001000,
        S_Q_DEP   = 13'b0000000010000,
        S_Q_CMP   = 13'b0000000100000,
        S_Q_LIFT  = 13'b0000001000000,
        S_Q_LIFTW = 13'b0000010000000,
        S_Q_UP    = 13'b0000100000000,
        S_Q_UPW   = 13'b0001000000000,
        S_Q_FIN   = 13'b0010000000000,
        S_Q_FINW  = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } t_state;

    function automatic logic in_range(input logic [NODE_W-1:0] x);
        in_range = (32'(x) < NODES);
    endfunction

    // Highest set bit of a nonzero depth difference, clamped to the top level.
    function automatic logic [LW-1:0] lift_level(input logic [DEPTH_W-1:0] d);
        logic [3:0] tb;
        tb = '0;
        for (int k = 0; k < DEPTH_W; k++) begin
            if (d[k]) tb = 4'(k);
        end
        lift_level = (32'(tb) >= LEVELS) ? TOP_LV : LW'(tb);
    endfunction

    t_state              r_state, n_state;
    logic [NW-1:0]       r_u, n_u;
    logic [NW-1:0]       r_v, n_v;
    logic [DEPTH_W-1:0]  r_d, n_d;
    logic [LW-1:0]       r_lv, n_lv;
    logic [NW-1:0]       r_i, n_i;
    logic [LW-1:0]       r_j, n_j;
    logic                r_ok, n_ok;
    t_result             r_res, n_res;

    // RAM ports
    logic                jw_en;
    logic [JAW-1:0]      jw_addr;
    logic [ENTRY_W-1:0]  jw_data;
    logic [JAW-1:0]      jr_addr0, jr_addr1;
    logic [ENTRY_W-1:0]  jr_data0, jr_data1;
    logic                dw_en;
    logic [NW-1:0]       dw_addr;
    logic [DEPTH_W-1:0]  dw_data;
    logic [NW-1:0]       dr_addr0, dr_addr1;
    logic [DEPTH_W-1:0]  dr_data0, dr_data1;

    logic [CW-1:0]       lim;
    logic                last_i;
    logic                load_has;
    logic [LW-1:0]       lift_lv;

    lcal_ram #(.W(ENTRY_W), .DEPTH(NODES << LW), .AW(JAW)) u_jump (
        .i_clk    (i_clk),
        .i_we     (jw_en),
        .i_waddr  (jw_addr),
        .i_wdata  (jw_data),
        .i_raddr0 (jr_addr0),
        .i_raddr1 (jr_addr1),
        .o_rdata0 (jr_data0),
        .o_rdata1 (jr_data1)
    );

    lcal_ram #(.W(DEPTH_W), .DEPTH(NODES), .AW(NW)) u_depth (
        .i_clk    (i_clk),
        .i_we     (dw_en),
        .i_waddr  (dw_addr),
        .i_wdata  (dw_data),
        .i_raddr0 (dr_addr0),
        .i_raddr1 (dr_addr1),
        .o_rdata0 (dr_data0),
        .o_rdata1 (dr_data1)
    );

    assign lim = (CW'(i_node_count) < CW'(NODES)) ? CW'(i_node_count) : CW'(NODES);
    assign last_i   = ((CW'(r_i) + CW'(1)) == lim);
    assign load_has = !i_is_root && in_range(i_node_b);
    assign lift_lv  = lift_level(r_d);

    // Build reads level j-1 and writes level j only, so no entry is read in
    // the same pass that writes it; writes land before any later read issues.
    always_comb begin
        n_state  = r_state;
        n_u      = r_u;
        n_v      = r_v;
        n_d      = r_d;
        n_lv     = r_lv;
        n_i      = r_i;
        n_j      = r_j;
        n_ok     = r_ok;
        n_res    = r_res;
        jw_en    = 1'b0;
        jw_addr  = '0;
        jw_data  = '0;
        jr_addr0 = '0;
        jr_addr1 = '0;
        dw_en    = 1'b0;
        dw_addr  = '0;
        dw_data  = '0;
        dr_addr0 = '0;
        dr_addr1 = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_LOAD: begin
                            if (in_range(i_node_a)) begin
                                jw_en   = 1'b1;
                                jw_addr = {NW'(i_node_a), LW'(0)};
                                jw_data = {load_has, load_has ? i_node_b : NODE_W'(0)};
                                dw_en   = 1'b1;
                                dw_addr = NW'(i_node_a);
                                dw_data = i_node_depth;
                            end
                        end
                        OP_BUILD: begin
                            n_i = '0;
                            n_j = LW'(1);
                            if (lim != '0 && LEVELS > 1) n_state = S_BLD_A;
                        end
                        OP_QUERY: begin
                            n_u = NW'(i_node_a);
                            n_v = NW'(i_node_b);
                            if (in_range(i_node_a) && in_range(i_node_b)) begin
                                n_state = S_Q_DEP;
                            end else begin
                                n_res   = '0;
                                n_state = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BLD_A: begin
                jr_addr0 = {r_i, r_j - LW'(1)};
                n_state  = S_BLD_B;
            end
            S_BLD_B: begin
                n_ok     = jr_data0[NODE_W] && in_range(jr_data0[NODE_W-1:0]);
                jr_addr0 = {NW'(jr_data0[NODE_W-1:0]), r_j - LW'(1)};
                n_state  = S_BLD_C;
            end
            S_BLD_C: begin
                jw_en   = 1'b1;
                jw_addr = {r_i, r_j};
                jw_data = r_ok ? jr_data0 : '0;
                n_state = S_BLD_A;
                if (last_i) begin
                    n_i = '0;
                    n_j = r_j + LW'(1);
                    if (r_j == TOP_LV) n_state = S_IDLE;
                end else begin
                    n_i = r_i + NW'(1);
                end
            end
            S_Q_DEP: begin
                dr_addr0 = r_u;
                dr_addr1 = r_v;
                n_state  = S_Q_CMP;
            end
            S_Q_CMP: begin
                // u becomes the deeper node
                if (dr_data0 < dr_data1) begin
                    n_u = r_v;
                    n_v = r_u;
                    n_d = dr_data1 - dr_data0;
                end else begin
                    n_d = dr_data0 - dr_data1;
                end
                n_state = S_Q_LIFT;
            end
            S_Q_LIFT: begin
                if (r_d == '0) begin
                    if (r_u == r_v) begin
                        n_res   = '{found: 1'b1, ancestor: NODE_W'(r_u)};
                        n_state = S_DONE;
                    end else begin
                        n_lv    = TOP_LV;
                        n_state = S_Q_UP;
                    end
                end else begin
                    n_lv     = lift_lv;
                    jr_addr0 = {r_u, lift_lv};
                    n_state  = S_Q_LIFTW;
                end
            end
            S_Q_LIFTW: begin
                if (!jr_data0[NODE_W] || !in_range(jr_data0[NODE_W-1:0])) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_u     = NW'(jr_data0[NODE_W-1:0]);
                    n_d     = r_d - (DEPTH_W'(1) << r_lv);
                    n_state = S_Q_LIFT;
                end
            end
            S_Q_UP: begin
                jr_addr0 = {r_u, r_lv};
                jr_addr1 = {r_v, r_lv};
                n_state  = S_Q_UPW;
            end
            S_Q_UPW: begin
                if (jr_data0[NODE_W] && jr_data1[NODE_W] &&
                    jr_data0[NODE_W-1:0] != jr_data1[NODE_W-1:0] &&
                    in_range(jr_data0[NODE_W-1:0]) && in_range(jr_data1[NODE_W-1:0])) begin
                    n_u = NW'(jr_data0[NODE_W-1:0]);
                    n_v = NW'(jr_data1[NODE_W-1:0]);
                end
                if (r_lv == '0) begin
                    n_state = S_Q_FIN;
                end else begin
                    n_lv    = r_lv - LW'(1);
                    n_state = S_Q_UP;
                end
            end
            S_Q_FIN: begin
                jr_addr0 = {r_u, LW'(0)};
                jr_addr1 = {r_v, LW'(0)};
                n_state  = S_Q_FINW;
            end
            S_Q_FINW: begin
                if (jr_data0[NODE_W] && jr_data1[NODE_W] &&
                    jr_data0[NODE_W-1:0] == jr_data1[NODE_W-1:0]) begin
                    n_res = '{found: 1'b1, ancestor: jr_data0[NODE_W-1:0]};
                end else begin
                    n_res = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_u   <= n_u;
        r_v   <= n_v;
        r_d   <= n_d;
        r_lv  <= n_lv;
        r_i   <= n_i;
        r_j   <= n_j;
        r_ok  <= n_ok;
        r_res <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* sv/lowest_common_ancestor_lifting.sv */
// Top level: stream ports, APB node_count register, output register.
// Depends on lcal_pkg, lcal_ctrl (with lcal_ram) and the assertion macro header.
//
//  Channel   Dir  Handshake                 Payload
//  s_axis    in   s_axis_tvalid/tready      tuser: operation; tdata: node fields
//  m_axis    out  m_axis_tvalid/tready      tdata: ancestor, found
//  APB       in   psel/penable/pwrite       node_count at byte address 0
//
// Load writes its entry from idle. Build: three jump-RAM accesses per entry (read,
// dependent read, write) for each of min(node_count, NODES) nodes and levels 1 to
// LEVELS-1, one RAM port path. Query: depth compare, lifts, descent, parent compare.
// One item in flight; the input is taken again as soon as the result sits in the
// output register, which holds it while m_axis_tready is low.
// Reset (i_rst_n, synchronous) clears control only; RAM contents stay undefined.
`default_nettype none

module lowest_common_ancestor_lifting import lcal_pkg::*; #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    output      logic               s_axis_tready,
    input  wire logic [31:0]        s_axis_tdata,   // node_a, node_b, is_root, node_depth, pad
    input  wire logic [1:0]         s_axis_tuser,   // operation
    output      logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output      logic [15:0]        m_axis_tdata,   // ancestor, found, pad
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

`include "lowest_common_ancestor_lifting_assert.svh"

    logic [CNT_W-1:0] r_node_count;
    logic             r_out_valid;
    t_result          r_out;
    logic             out_free;
    logic             res_valid;
    t_result          res;
    logic             in_ready;

    assign pready   = 1'b1;
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_NODE_COUNT) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NODE_COUNT) ? PDATA_W'(r_node_count) : '0;

    lcal_ctrl #(.NODES(NODES), .LEVELS(LEVELS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (in_ready),
        .i_op         (t_op'(s_axis_tuser)),
        .i_node_a     (s_axis_tdata[9:0]),
        .i_node_b     (s_axis_tdata[19:10]),
        .i_is_root    (s_axis_tdata[20]),
        .i_node_depth (s_axis_tdata[30:21]),
        .i_node_count (r_node_count),
        .i_res_ready  (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.found, r_out.ancestor};

    // A query keeps the engine busy in the cycle after its transfer.
    `LCAL_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_QUERY, !s_axis_tready, "input ready right after a query transfer")
    // The output register only fills from a finished query.
    `LCAL_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(res_valid), "result shown without a finished query")
    // A miss reports ancestor zero.
    `LCAL_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, res_valid && !res.found, res.ancestor == '0, "miss with nonzero ancestor")

endmodule

`default_nettype wire

/* verif/lca_answer_checker.sv */
// Answer checker for lowest_common_ancestor_lifting: watches the APB port and both streams,
// keeps its own jump table and depth store, and compares each answer with its prediction.
// Depends on lcal_pkg.
`default_nettype none

module lca_answer_checker import lcal_pkg::*; #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    input  wire logic               i_s_tready,
    input  wire logic [31:0]        i_s_tdata,   // node_a, node_b, is_root, node_depth, pad
    input  wire logic [1:0]         i_s_tuser,   // operation
    input  wire logic               i_m_tvalid,
    input  wire logic               i_m_tready,
    input  wire logic [15:0]        i_m_tdata,   // ancestor, found, pad
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic               i_pready,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [PDATA_W-1:0] i_pwdata,
    output      int                 o_mismatches,
    output      int                 o_outstanding
);

    // up_node[n][j] is the ancestor 2^j steps above node n, valid when up_ok is set
    logic [NODE_W-1:0]  up_node [NODES][LEVELS];
    logic               up_ok   [NODES][LEVELS];
    logic [DEPTH_W-1:0] depth_of [NODES];
    logic [CNT_W-1:0]   span_reg;
    t_result            answers_due [$];
    t_result            got;
    t_result            want;
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // A parent outside the node range counts as a root; a node outside it is dropped.
    function automatic void apply_load(logic [NODE_W-1:0] node, logic [NODE_W-1:0] parent,
                                       logic root, logic [DEPTH_W-1:0] dep);
        logic has;
        has = !root && (int'(parent) < NODES);
        if (int'(node) < NODES) begin
            up_node[node][0] = has ? parent : '0;
            up_ok[node][0]   = has;
            depth_of[node]   = dep;
        end
    endfunction

    // Level by level, so every level j-1 entry is complete before level j reads it.
    function automatic void rebuild_jumps();
        int                span;
        logic [NODE_W-1:0] mid;
        span = (span_reg < NODES) ? int'(span_reg) : NODES;
        for (int j = 1; j < LEVELS; j++) begin
            for (int i = 0; i < span; i++) begin
                mid = up_node[i][j-1];
                if (up_ok[i][j-1] && int'(mid) < NODES) begin
                    up_node[i][j] = up_node[mid][j-1];
                    up_ok[i][j]   = up_ok[mid][j-1];
                end else begin
                    up_node[i][j] = '0;
                    up_ok[i][j]   = 1'b0;
                end
            end
        end
    endfunction

    function automatic t_result lift_query(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        t_result           r;
        logic [NODE_W-1:0] u;
        logic [NODE_W-1:0] v;
        int                gap;
        int                hb;
        r = '0;
        if (int'(a) >= NODES || int'(b) >= NODES) return r;
        u = a;
        v = b;
        if (depth_of[u] < depth_of[v]) begin
            u = b;
            v = a;
        end
        gap = int'(depth_of[u]) - int'(depth_of[v]);
        // bring the deeper node up to the other's depth, largest step first
        while (gap != 0) begin
            hb = 0;
            for (int k = 0; k < 32; k++) begin
                if (gap[k]) hb = k;
            end
            if (hb > LEVELS - 1) hb = LEVELS - 1;
            if (!up_ok[u][hb] || int'(up_node[u][hb]) >= NODES) return r;
            u = up_node[u][hb];
            gap -= (1 << hb);
        end
        if (u == v) begin
            r.found    = 1'b1;
            r.ancestor = u;
            return r;
        end
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (up_ok[u][k] && up_ok[v][k] && up_node[u][k] != up_node[v][k] &&
                    int'(up_node[u][k]) < NODES && int'(up_node[v][k]) < NODES) begin
                u = up_node[u][k];
                v = up_node[v][k];
            end
        end
        if (up_ok[u][0] && up_ok[v][0] && up_node[u][0] == up_node[v][0]) begin
            r.found    = 1'b1;
            r.ancestor = up_node[u][0];
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, int want_val, int got_val);
        mismatch_count++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want_val,
                 got_val);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            span_reg = CNT_RESET;
            answers_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_NODE_COUNT)
                span_reg = i_pwdata[CNT_W-1:0];
            if (i_s_tvalid && i_s_tready) begin
                case (t_op'(i_s_tuser))
                    OP_LOAD:  apply_load(i_s_tdata[9:0], i_s_tdata[19:10], i_s_tdata[20],
                                         i_s_tdata[30:21]);
                    OP_BUILD: rebuild_jumps();
                    OP_QUERY: answers_due.insert(answers_due.size(),
                                                 lift_query(i_s_tdata[9:0],
                                                            i_s_tdata[19:10]));
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[NODE_W:0]);
                if (answers_due.size() == 0) begin
                    note_mismatch("unrequested answer", -1, int'(got));
                end else begin
                    want = answers_due.pop_front();
                    if (got.ancestor !== want.ancestor)
                        note_mismatch("ancestor", want.ancestor, got.ancestor);
                    if (got.found !== want.found)
                        note_mismatch("found", want.found, got.found);
                end
            end
        end
        o_outstanding <= answers_due.size();
    end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Testbench top for lowest_common_ancestor_lifting: drives APB writes and load, build and
// query transfers, stalls both streams, and reports the verdict. Depends on lcal_pkg,
// the block and lca_answer_checker.
`default_nettype none

module tb_top import lcal_pkg::*; ();

    localparam int NODES          = 1024;
    localparam int LEVELS         = 10;
    localparam int ITEM_TARGET    = 2000;
    localparam int BIG_AFTER      = 800;
    // longest quiet stretch: a full 1024-node build plus the settle wait after it
    localparam int WATCHDOG_LIMIT = 300000;
    localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = '0;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [31:0]        s_axis_tdata  = '0;
    t_op                s_axis_tuser  = OP_LOAD;
    logic               m_axis_tready = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    wire                s_axis_tready;
    wire                m_axis_tvalid;
    wire  [15:0]        m_axis_tdata;
    wire  [PDATA_W-1:0] prdata;
    wire                pready;

    int                 item_count   = 0;
    int                 tx_idle_pct  = 21;
    int                 rx_idle_pct  = 81;
    int                 settle_span  = 80;
    int                 stall_cycles = 0;
    int                 mismatches;
    int                 outstanding;
    bit                 big_done     = 1'b0;
    int                 span;
    logic [DEPTH_W-1:0] tree_depth [NODES];

    lowest_common_ancestor_lifting #(.NODES(NODES), .LEVELS(LEVELS)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lca_answer_checker #(.NODES(NODES), .LEVELS(LEVELS)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                    (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_op op, input logic [9:0] a, input logic [9:0] b,
                             input logic root, input logic [9:0] dep);
        if (item_count < 700) begin
            tx_idle_pct = 21;
            rx_idle_pct = 81;
        end else if (item_count < 1400) begin
            tx_idle_pct = 81;
            rx_idle_pct = 21;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, dep, root, b, a};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op != OP_NONE) item_count++;
        @(negedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settle_span = 3 * (LEVELS - 1) * ((value > NODES) ? NODES : int'(value)) + 80;
    endtask

    // Drain answers, then give a build that may still be running time to finish.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (settle_span) @(negedge i_clk);
    endtask

    // Mostly consistent trees (parent below the node, depth one more); some noise.
    task automatic load_node(input int node, input int range);
        int             roll;
        int             parent;
        logic           root;
        logic [9:0]     dep;
        roll = $urandom_range(99);
        if (node == 0 || roll < 8) begin
            root   = 1'b1;
            parent = $urandom_range(NODES - 1);
            dep    = (roll < 3) ? 10'($urandom_range(1023)) : '0;
        end else if (roll < 88) begin
            root   = 1'b0;
            parent = (roll < 50) ? node - 1 : int'($urandom_range(node - 1));
            dep    = tree_depth[parent] + 10'd1;
        end else begin
            root   = 1'b0;
            parent = $urandom_range(range - 1);
            dep    = 10'($urandom_range(1023));
        end
        tree_depth[node] = dep;
        send_item(OP_LOAD, 10'(node), 10'(parent), root, dep);
    endtask

    task automatic populate(input int range);
        for (int i = 0; i < range; i++) load_node(i, range);
        send_item(OP_BUILD, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                  1'($urandom_range(1)), 10'($urandom_range(1023)));
    endtask

    task automatic mixed_traffic(input int range, input int count);
        int         roll;
        logic [9:0] a;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            a    = 10'($urandom_range(range - 1));
            if (roll < 62)
                send_item(OP_QUERY, a, 10'($urandom_range(range - 1)), 1'($urandom_range(1)),
                          10'($urandom_range(1023)));
            else if (roll < 68)
                send_item(OP_QUERY, a, a, 1'($urandom_range(1)), 10'($urandom_range(1023)));
            else if (roll < 82)
                load_node(a, range);
            else if (roll < 90)
                send_item(OP_BUILD, a, 10'($urandom_range(1023)), 1'($urandom_range(1)),
                          10'($urandom_range(1023)));
            else
                send_item(OP_NONE, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          1'($urandom_range(1)), 10'($urandom_range(1023)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // small hand-built forest: 0-1-{2,3}, lone root 4, root 5 with a bogus depth
        write_count(11'd6);
        send_item(OP_NONE, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF);
        send_item(OP_LOAD, 10'd0, 10'd0, 1'b1, 10'd0);
        send_item(OP_LOAD, 10'd1, 10'd0, 1'b0, 10'd1);
        send_item(OP_LOAD, 10'd2, 10'd1, 1'b0, 10'd2);
        send_item(OP_LOAD, 10'd3, 10'd1, 1'b0, 10'd2);
        send_item(OP_LOAD, 10'd4, 10'h3FF, 1'b1, 10'd0);
        send_item(OP_LOAD, 10'd5, 10'd3, 1'b1, 10'h3FF);
        send_item(OP_BUILD, 10'd0, 10'd0, 1'b0, 10'd0);
        send_item(OP_QUERY, 10'd2, 10'd3, 1'b0, 10'd0);     // siblings
        send_item(OP_QUERY, 10'd3, 10'd2, 1'b1, 10'h3FF);
        send_item(OP_QUERY, 10'd2, 10'd2, 1'b0, 10'd0);     // same node
        send_item(OP_QUERY, 10'd0, 10'd3, 1'b0, 10'd0);     // one is the other's ancestor
        send_item(OP_QUERY, 10'd2, 10'd4, 1'b0, 10'd0);     // separate trees
        send_item(OP_QUERY, 10'd5, 10'd0, 1'b0, 10'd0);     // lift runs off a root
        send_item(OP_QUERY, 10'd4, 10'd4, 1'b0, 10'd0);
        wait_quiet();

        write_count(11'd1);
        populate(1);
        mixed_traffic(1, 20);
        wait_quiet();

        while (item_count < ITEM_TARGET) begin
            if (!big_done && item_count >= BIG_AFTER) begin
                big_done = 1'b1;
                write_count(11'd1024);
                populate(NODES);
                mixed_traffic(NODES, 60);
                wait_quiet();
                // count above the node range clamps to the full table
                write_count(11'h7FF);
                send_item(OP_BUILD, 10'h3FF, 10'h3FF, 1'b1, 10'h3FF);
                mixed_traffic(NODES, 30);
                wait_quiet();
                // zero count: builds leave the table untouched
                write_count(11'd0);
                send_item(OP_BUILD, 10'd0, 10'd0, 1'b0, 10'd0);
                mixed_traffic(NODES, 20);
                wait_quiet();
            end else begin
                span = $urandom_range(48, 2);
                write_count(11'(span));
                populate(span);
                mixed_traffic(span, $urandom_range(40, 20));
                wait_quiet();
            end
        end

        if (mismatches == 0 && outstanding == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+sv
sv/lcal_pkg.sv
sv/lcal_ram.sv
sv/lcal_ctrl.sv
sv/lowest_common_ancestor_lifting.sv
verif/lca_answer_checker.sv
verif/tb_top.sv
